/* design/ost_pkg.sv */
// Shared types, codes and default sizes for the ordered unique set table.
package ost_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    // Per-cycle update strobes broadcast along the cell row
    typedef struct packed {
        logic append;   // write key into the cell at position held
        logic shift;    // cells at or above the hit take their upper neighbour
    } ctl_t;

endpackage

/* design/ost_cell.sv */
// One storage cell of the set: entry register, comparator and shift mux.
module ost_cell #(
    parameter int VALUE_WIDTH = ost_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = 5,
    parameter int POSITION    = 0
) (
    input  logic                   clk,
    input  ost_pkg::ctl_t          ctl,
    input  logic [CNT_W-1:0]       held,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [VALUE_WIDTH-1:0] next_entry,
    input  logic                   prefix_in,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   hit,
    output logic                   prefix_out
);
    import ost_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   live;

    // only entries below the count take part
    assign live       = held > CNT_W'(POSITION);
    assign hit        = live && (entry_reg == key);
    assign prefix_out = prefix_in || hit;
    assign entry      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.append && (held == CNT_W'(POSITION)))
        begin
            entry_next = key;
        end
        else if (ctl.shift && prefix_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* design/ost_chain.sv */
// Row of set cells with the hit prefix chain and neighbour shift links.
module ost_chain #(
    parameter int CAPACITY    = ost_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ost_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = 5
) (
    input  logic                   clk,
    input  ost_pkg::ctl_t          ctl,
    input  logic [CNT_W-1:0]       held,
    input  logic [VALUE_WIDTH-1:0] key,
    output logic [CAPACITY-1:0]    hit
);
    import ost_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
    logic [CAPACITY:0]      prefix_w;

    assign prefix_w[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] upper;

        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = entry_w[i];
        end
        else
        begin : g_mid
            assign upper = entry_w[i+1];
        end

        ost_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .POSITION    (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .held       (held),
            .key        (key),
            .next_entry (upper),
            .prefix_in  (prefix_w[i]),
            .entry      (entry_w[i]),
            .hit        (hit[i]),
            .prefix_out (prefix_w[i+1])
        );
    end

endmodule

/* design/ordered_unique_set_table_unit.sv */
// Top level of the ordered unique set table: handshakes, count and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: cmd and
//   value. Commands are insert, lookup, remove and clear. Output channel
//   (out_valid/out_ready) returns exactly one result transaction per command:
//   status, index and the element count after the command.
//   A command is held in an input register and executed against the cell
//   row once the result slot is free or being emptied: every cell compares
//   its entry with the key at once, a prefix chain marks the cells that shift
//   down on remove, and the append lands in the cell at the count position.
//   A command passes the input register, then the result register.
//   Throughput: one command per cycle while the receiver keeps up; the cell
//   row evaluates one command a cycle.
//   Stall: while a result waits, one further command may be accepted and
//   held; in_ready drops until the waiting result is taken.
//   Reset: clears the count and both valid flags; entry contents are not
//   cleared and are never read above the count.
module ordered_unique_set_table_unit #(
    parameter int CAPACITY    = ost_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ost_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ost_pkg::CMD_W-1:0]     cmd,
    input  logic [ost_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ost_pkg::STATUS_W-1:0]  status,
    output logic [ost_pkg::INDEX_W-1:0]   index,
    output logic [ost_pkg::COUNT_W-1:0]   count
);
    import ost_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // input holding register
    logic                   pend_reg;
    cmd_t                   pcmd_reg;
    logic [VALUE_WIDTH-1:0] pval_reg;

    // set state
    logic [CNT_W-1:0]       held_reg;
    logic [CNT_W-1:0]       held_next;

    // result register
    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [POS_W-1:0]       idx_reg;
    logic [POS_W-1:0]       idx_next;
    logic [CNT_W-1:0]       cnt_reg;

    logic                   exec;
    logic                   full;
    logic                   found;
    logic [CAPACITY-1:0]    hit;
    logic [POS_W-1:0]       hit_pos;
    ctl_t                   ctl;

    // command executes when the result slot is free or being emptied
    assign exec     = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || exec;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = INDEX_W'(idx_reg);
    assign count     = COUNT_W'(cnt_reg);

    ost_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk  (clk),
        .ctl  (ctl),
        .held (held_reg),
        .key  (pval_reg),
        .hit  (hit)
    );

    // values in the set are distinct, so at most one cell hits
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    assign found = |hit;
    assign full  = held_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        ctl         = '0;
        status_next = ST_OK;
        idx_next    = '0;
        held_next   = held_reg;
        case (pcmd_reg)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (found)
                begin
                    status_next = ST_DUP;
                end
                else
                begin
                    ctl.append = exec;
                    idx_next   = POS_W'(held_reg);
                    held_next  = held_reg + CNT_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                if (found)
                begin
                    idx_next = hit_pos;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            CMD_REMOVE:
            begin
                if (found)
                begin
                    ctl.shift = exec;
                    idx_next  = hit_pos;
                    held_next = held_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            CMD_CLEAR:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pend_reg <= 1'b1;
            end
            else if (exec)
            begin
                pend_reg <= 1'b0;
            end

            if (exec)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pcmd_reg <= cmd_t'(cmd);
            pval_reg <= VALUE_WIDTH'(value);
        end
        if (exec)
        begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
            cnt_reg    <= held_next;
        end
    end

    // count never exceeds capacity
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // distinct contents give at most one hit
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $onehot0(hit))
        else $error("more than one cell matched");

    // clear empties the set and reports zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && pcmd_reg == CMD_CLEAR) |=> (held_reg == '0 && cnt_reg == '0
            && status_reg == ST_OK))
        else $error("clear did not empty the set");

    // a successful insert grows the count by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && ctl.append) |=> (held_reg == $past(held_reg) + CNT_W'(1)))
        else $error("insert did not grow the count");

    // a result is registered only for an executed transaction
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !exec) |=> !out_valid_reg)
        else $error("result appeared without a command");

endmodule
